[rtl/poisson_pmf_cdf_evaluator_top_macros.svh]
// Assertion macros for the Poisson mass and cumulative probability evaluator.
// Used by the port checker; depends on nothing else.
`ifndef POISSON_PMF_CDF_EVALUATOR_TOP_MACROS_SVH
`define POISSON_PMF_CDF_EVALUATOR_TOP_MACROS_SVH

// Clocked property with a disable condition.
`define PPCE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication from one condition to another on the same clock.
`define PPCE_ASSERT_IMPLY(label, clk, rst, cond, concl, msg) \
   `PPCE_ASSERT_CLK(label, clk, rst, (cond) |-> (concl), msg)

// Implication whose conclusion is checked in the next cycle.
`define PPCE_ASSERT_NEXT(label, clk, rst, cond, concl, msg) \
   `PPCE_ASSERT_CLK(label, clk, rst, (cond) |=> (concl), msg)

`endif

[rtl/ppce_pkg.sv]
// Shared types, constants and the microcode table of the Poisson evaluator.
// Depends on nothing; used by the top, divider, checker and testbench.
`timescale 1ns / 1ps

package ppce_pkg;

   // Field and datapath widths.
   localparam int MAX_K        = 255;
   localparam int K_W          = $clog2(MAX_K + 1);
   localparam int N_W          = K_W + 1;
   localparam int COUNT_W      = 9;
   localparam int RATE_W       = 21;
   localparam int RATE_FRAC    = 16;
   localparam int EXP_W        = 32;
   localparam int OUT_W        = 32;
   localparam int CSR_W        = 32;
   localparam int CSR_INDEX_W  = 1;
   localparam int HALF_W       = 32;
   localparam int TERM_W       = 64;
   localparam int MUL_W        = 2 * HALF_W;
   localparam int PROD_W       = TERM_W + RATE_W;
   localparam int DIVIDEND_W   = PROD_W - RATE_FRAC;

   // Divider: one quotient digit per step.
   localparam int DIV_W        = K_W;
   localparam int DIGIT_W      = 8;
   localparam int DIV_DIGITS   = (DIVIDEND_W + DIGIT_W - 1) / DIGIT_W;
   localparam int DIV_REG_W    = DIV_DIGITS * DIGIT_W;
   localparam int DIV_CNT_W    = $clog2(DIV_DIGITS);

   // Reset values of the registers and the value 1.0 in UQ32.32.
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);
   localparam logic [EXP_W-1:0]  EXP_RESET  = EXP_W'(1580030169);
   localparam logic [TERM_W-1:0] ONE_Q32    = TERM_W'(1) << HALF_W;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP  = 1'b1;

   // Microcode steps.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_LO    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_HI    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_ACC       = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV_INIT  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DIV       = 4'd6;
   localparam logic [STEP_W-1:0] STEP_TERM      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SUM       = 4'd8;
   localparam logic [STEP_W-1:0] STEP_SCALE     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_SCALE_HI  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_SCALE_ADD = 4'd11;
   localparam logic [STEP_W-1:0] STEP_MASS      = 4'd12;
   localparam logic [STEP_W-1:0] STEP_SUM_HI    = 4'd13;
   localparam logic [STEP_W-1:0] STEP_SUM_ADD   = 4'd14;
   localparam logic [STEP_W-1:0] STEP_CUM       = 4'd15;

   // Sequencing condition of a control word.
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_WAIT_START,
      COND_LOOP_DONE,
      COND_DIV_MORE
   } cond_type;

   // Multiplier operand selection.
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_RATE_LO,
      MUL_RATE_HI,
      MUL_EXP_TERM_LO,
      MUL_EXP_TERM_HI,
      MUL_EXP_SUM_LO,
      MUL_EXP_SUM_HI
   } mul_sel_type;

   // Accumulator operation.
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LOAD_FULL,
      ACC_ADD_SHIFT,
      ACC_LOAD_HIGH,
      ACC_ADD
   } acc_op_type;

   // Other datapath operations.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_TERM,
      OP_SUM,
      OP_STORE_MASS,
      OP_STORE_CUM
   } op_type;

   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      op_type            op;
   } ucode_word_type;

   // Control group from the sequencer to the divider.
   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   // The microprogram: one control word per step.
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '{cond: COND_NEXT, target: STEP_IDLE, mul_sel: MUL_NONE,
            acc_op: ACC_NONE, op: OP_NONE};
      case (step)
         STEP_IDLE: begin
            w.cond = COND_WAIT_START;
         end
         STEP_CHECK: begin
            w.cond   = COND_LOOP_DONE;
            w.target = STEP_SCALE;
         end
         STEP_MUL_LO: begin
            w.mul_sel = MUL_RATE_LO;
         end
         STEP_MUL_HI: begin
            w.mul_sel = MUL_RATE_HI;
            w.acc_op  = ACC_LOAD_FULL;
         end
         STEP_ACC: begin
            w.acc_op = ACC_ADD_SHIFT;
         end
         STEP_DIV_INIT: begin
            w.op = OP_DIV_INIT;
         end
         STEP_DIV: begin
            w.op     = OP_DIV_STEP;
            w.cond   = COND_DIV_MORE;
            w.target = STEP_DIV;
         end
         STEP_TERM: begin
            w.op = OP_TERM;
         end
         STEP_SUM: begin
            w.op     = OP_SUM;
            w.cond   = COND_JUMP;
            w.target = STEP_CHECK;
         end
         STEP_SCALE: begin
            w.mul_sel = MUL_EXP_TERM_LO;
         end
         STEP_SCALE_HI: begin
            w.mul_sel = MUL_EXP_TERM_HI;
            w.acc_op  = ACC_LOAD_HIGH;
         end
         STEP_SCALE_ADD: begin
            w.acc_op = ACC_ADD;
         end
         STEP_MASS: begin
            w.op      = OP_STORE_MASS;
            w.mul_sel = MUL_EXP_SUM_LO;
         end
         STEP_SUM_HI: begin
            w.mul_sel = MUL_EXP_SUM_HI;
            w.acc_op  = ACC_LOAD_HIGH;
         end
         STEP_SUM_ADD: begin
            w.acc_op = ACC_ADD;
         end
         STEP_CUM: begin
            w.op     = OP_STORE_CUM;
            w.cond   = COND_JUMP;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_JUMP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/ppce_digit_div.sv]
// Iterative divider of the scaled product by the term index, one 8-bit digit a step.
// Depends on ppce_pkg.
`timescale 1ns / 1ps

module ppce_digit_div (
   input  logic                              clock,
   input  logic                              reset,
   input  ppce_pkg::div_ctrl_type            ctrl,
   input  logic [ppce_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [ppce_pkg::DIV_W-1:0]        divisor,
   output logic [ppce_pkg::DIV_REG_W-1:0]    quotient,
   output logic                              more
);

   logic [ppce_pkg::DIV_REG_W-1:0] shift_ff, shift_in;
   logic [ppce_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [ppce_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ppce_pkg::DIV_W-1:0]     rem_step;
   logic [ppce_pkg::DIV_W:0]       trial;
   logic [ppce_pkg::DIGIT_W-1:0]   digit;

   // Restoring division over the top digit of the shift register.
   always_comb begin
      rem_step = rem_ff;
      trial    = '0;
      digit    = '0;
      for (int i = 0; i < ppce_pkg::DIGIT_W; i++) begin
         trial = {rem_step, shift_ff[ppce_pkg::DIV_REG_W-1-i]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            digit[ppce_pkg::DIGIT_W-1-i] = 1'b1;
         end
         rem_step = trial[ppce_pkg::DIV_W-1:0];
      end
   end

   // Next values: the dividend shifts out as the quotient shifts in.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (ctrl.init) begin
         shift_in = ppce_pkg::DIV_REG_W'(dividend);
         rem_in   = '0;
         cnt_in   = '0;
      end else if (ctrl.step) begin
         shift_in = {shift_ff[ppce_pkg::DIV_REG_W-ppce_pkg::DIGIT_W-1:0], digit};
         rem_in   = rem_step;
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign quotient = shift_ff;
   assign more     = (cnt_ff != ppce_pkg::DIV_CNT_W'(ppce_pkg::DIV_DIGITS - 1));

endmodule

[rtl/poisson_pmf_cdf_evaluator_top.sv]
// Top level of the Poisson mass and cumulative probability evaluator.
// Depends on ppce_pkg and ppce_digit_div.
//
//   Channel   Handshake              Payload
//   request   start / busy           req_event_count
//   response  rsp_valid (strobe)     rsp_mass_prob, rsp_cumulative_prob
//   csr       csr_write_enable       csr_index, csr_write_data
//
// A word with count k >= 0 computes min(k, MAX_K) terms before the response strobe;
// a negative count computes none. Each term costs one step counter
// pass through the microprogram, dominated by nine digit steps of the divider.
// busy is low again in the strobe cycle, so the next word may be taken then.
// Reset returns the step counter to idle and the registers to their defaults.
// The response is shown for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps

module poisson_pmf_cdf_evaluator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ppce_pkg::COUNT_W-1:0] req_event_count,
   output logic                                rsp_valid,
   output logic [ppce_pkg::OUT_W-1:0]          rsp_mass_prob,
   output logic [ppce_pkg::OUT_W-1:0]          rsp_cumulative_prob,
   input  logic                                csr_write_enable,
   input  logic [ppce_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ppce_pkg::CSR_W-1:0]          csr_write_data
);

   ppce_pkg::ucode_word_type       uword;
   ppce_pkg::div_ctrl_type         div_ctrl;

   logic [ppce_pkg::STEP_W-1:0]    pc_ff, pc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ppce_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic [ppce_pkg::EXP_W-1:0]     exp_ff, exp_in;
   logic [ppce_pkg::N_W-1:0]       n_ff, n_in;
   logic [ppce_pkg::K_W-1:0]       k_ff, k_in;
   logic                           neg_ff, neg_in;
   logic [ppce_pkg::TERM_W-1:0]    term_ff, term_in;
   logic [ppce_pkg::TERM_W-1:0]    sum_ff, sum_in;
   logic [ppce_pkg::MUL_W-1:0]     mul_ff, mul_in;
   logic [ppce_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [ppce_pkg::OUT_W-1:0]     mass_ff, mass_in;
   logic [ppce_pkg::OUT_W-1:0]     cum_ff, cum_in;

   logic                           accept;
   logic                           loop_done;
   logic                           div_more;
   logic [ppce_pkg::DIV_REG_W-1:0] quotient;
   logic [ppce_pkg::HALF_W-1:0]    mul_a, mul_b;
   logic [ppce_pkg::TERM_W:0]      sum_wide;
   logic [ppce_pkg::OUT_W-1:0]     scaled;

   // Control word of the current step.
   assign uword     = ppce_pkg::ucode_rom(pc_ff);
   assign busy      = (pc_ff != ppce_pkg::STEP_IDLE);
   assign accept    = start && !busy;
   assign loop_done = neg_ff || (n_ff > {1'b0, k_ff});

   // Step counter with conditional jumps.
   always_comb begin
      pc_in = pc_ff + 1'b1;
      case (uword.cond)
         ppce_pkg::COND_NEXT:       pc_in = pc_ff + 1'b1;
         ppce_pkg::COND_JUMP:       pc_in = uword.target;
         ppce_pkg::COND_WAIT_START: pc_in = accept ? pc_ff + 1'b1 : pc_ff;
         ppce_pkg::COND_LOOP_DONE:  pc_in = loop_done ? uword.target : pc_ff + 1'b1;
         ppce_pkg::COND_DIV_MORE:   pc_in = div_more ? uword.target : pc_ff + 1'b1;
         default:                   pc_in = ppce_pkg::STEP_IDLE;
      endcase
   end

   // Configuration registers.
   always_comb begin
      rate_in = rate_ff;
      exp_in  = exp_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ppce_pkg::CSR_RATE: rate_in = csr_write_data[ppce_pkg::RATE_W-1:0];
            ppce_pkg::CSR_EXP:  exp_in  = csr_write_data[ppce_pkg::EXP_W-1:0];
            default: begin
               rate_in = rate_ff;
               exp_in  = exp_ff;
            end
         endcase
      end
   end

   // Shared 32 by 32 multiplier and its operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uword.mul_sel)
         ppce_pkg::MUL_RATE_LO: begin
            mul_a = term_ff[ppce_pkg::HALF_W-1:0];
            mul_b = ppce_pkg::HALF_W'(rate_ff);
         end
         ppce_pkg::MUL_RATE_HI: begin
            mul_a = term_ff[ppce_pkg::TERM_W-1:ppce_pkg::HALF_W];
            mul_b = ppce_pkg::HALF_W'(rate_ff);
         end
         ppce_pkg::MUL_EXP_TERM_LO: begin
            mul_a = term_ff[ppce_pkg::HALF_W-1:0];
            mul_b = exp_ff;
         end
         ppce_pkg::MUL_EXP_TERM_HI: begin
            mul_a = term_ff[ppce_pkg::TERM_W-1:ppce_pkg::HALF_W];
            mul_b = exp_ff;
         end
         ppce_pkg::MUL_EXP_SUM_LO: begin
            mul_a = sum_ff[ppce_pkg::HALF_W-1:0];
            mul_b = exp_ff;
         end
         ppce_pkg::MUL_EXP_SUM_HI: begin
            mul_a = sum_ff[ppce_pkg::TERM_W-1:ppce_pkg::HALF_W];
            mul_b = exp_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = mul_a * mul_b;

   // Accumulator that joins the two partial products.
   always_comb begin
      prod_in = prod_ff;
      case (uword.acc_op)
         ppce_pkg::ACC_NONE:      prod_in = prod_ff;
         ppce_pkg::ACC_LOAD_FULL: prod_in = ppce_pkg::PROD_W'(mul_ff);
         ppce_pkg::ACC_ADD_SHIFT:
            prod_in = prod_ff + ppce_pkg::PROD_W'({mul_ff, {ppce_pkg::HALF_W{1'b0}}});
         ppce_pkg::ACC_LOAD_HIGH:
            prod_in = ppce_pkg::PROD_W'(mul_ff[ppce_pkg::MUL_W-1:ppce_pkg::HALF_W]);
         ppce_pkg::ACC_ADD:       prod_in = prod_ff + ppce_pkg::PROD_W'(mul_ff);
         default:                 prod_in = prod_ff;
      endcase
   end

   // Divider control and the scaled output, saturated and forced to zero when negative.
   assign div_ctrl.init = (uword.op == ppce_pkg::OP_DIV_INIT);
   assign div_ctrl.step = (uword.op == ppce_pkg::OP_DIV_STEP);
   assign sum_wide      = {1'b0, sum_ff} + {1'b0, term_ff};

   always_comb begin
      if (neg_ff) begin
         scaled = '0;
      end else if (|prod_ff[ppce_pkg::PROD_W-1:ppce_pkg::OUT_W]) begin
         scaled = '1;
      end else begin
         scaled = prod_ff[ppce_pkg::OUT_W-1:0];
      end
   end

   // Term, sum, loop index and result registers.
   always_comb begin
      term_in      = term_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      mass_in      = mass_ff;
      cum_in       = cum_ff;
      rsp_valid_in = 1'b0;
      if (accept) begin
         term_in = ppce_pkg::ONE_Q32;
         sum_in  = ppce_pkg::ONE_Q32;
         n_in    = ppce_pkg::N_W'(1);
         neg_in  = req_event_count[ppce_pkg::COUNT_W-1];
         if (int'(req_event_count[ppce_pkg::COUNT_W-2:0]) > ppce_pkg::MAX_K) begin
            k_in = ppce_pkg::K_W'(ppce_pkg::MAX_K);
         end else begin
            k_in = ppce_pkg::K_W'(req_event_count[ppce_pkg::COUNT_W-2:0]);
         end
      end
      case (uword.op)
         ppce_pkg::OP_TERM: begin
            if (|quotient[ppce_pkg::DIV_REG_W-1:ppce_pkg::TERM_W]) begin
               term_in = '1;
            end else begin
               term_in = quotient[ppce_pkg::TERM_W-1:0];
            end
         end
         ppce_pkg::OP_SUM: begin
            sum_in = sum_wide[ppce_pkg::TERM_W] ? '1 : sum_wide[ppce_pkg::TERM_W-1:0];
            n_in   = n_ff + 1'b1;
         end
         ppce_pkg::OP_STORE_MASS: begin
            mass_in = scaled;
         end
         ppce_pkg::OP_STORE_CUM: begin
            cum_in       = scaled;
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ppce_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= ppce_pkg::RATE_RESET;
         exp_ff       <= ppce_pkg::EXP_RESET;
         n_ff         <= '0;
         k_ff         <= '0;
         neg_ff       <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         exp_ff       <= exp_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         neg_ff       <= neg_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      term_ff <= term_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      mass_ff <= mass_in;
      cum_ff  <= cum_in;
      if (uword.mul_sel != ppce_pkg::MUL_NONE) begin
         mul_ff <= mul_in;
      end
   end

   ppce_digit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod_ff[ppce_pkg::PROD_W-1:ppce_pkg::RATE_FRAC]),
      .divisor  (n_ff[ppce_pkg::DIV_W-1:0]),
      .quotient (quotient),
      .more     (div_more)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mass_prob       = mass_ff;
   assign rsp_cumulative_prob = cum_ff;

endmodule

[rtl/ppce_checker.sv]
// Port-level checker of the Poisson evaluator and its bind to the top level.
// Depends on ppce_pkg and poisson_pmf_cdf_evaluator_top_macros.svh.
`timescale 1ns / 1ps
`include "poisson_pmf_cdf_evaluator_top_macros.svh"

module ppce_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [ppce_pkg::OUT_W-1:0] rsp_mass_prob,
   input logic [ppce_pkg::OUT_W-1:0] rsp_cumulative_prob
);

   // An accepted word keeps the block busy in the following cycle.
   `PPCE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not set busy")

   // The response strobe lasts one cycle, and the block is free while it shows.
   `PPCE_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "strobe held too long")
   `PPCE_ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_valid, !busy, "strobe while busy")

   // The mass term can never exceed the cumulative sum it belongs to.
   `PPCE_ASSERT_IMPLY(a_mass_le_cum, clock, reset, rsp_valid,
                      rsp_mass_prob <= rsp_cumulative_prob, "mass above cumulative")

   // A reset cycle leaves the block idle with no response pending in the next cycle.
   `PPCE_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !busy && !rsp_valid, "not idle after reset")

endmodule

bind poisson_pmf_cdf_evaluator_top ppce_checker u_checker (.*);

[tb/poisson_pmf_cdf_evaluator_top_tb.sv]
// Self-checking testbench for the Poisson mass and cumulative probability evaluator.
// Depends on ppce_pkg and poisson_pmf_cdf_evaluator_top; a directed table, then random phases.
// Expected words come from the table or a built-in predictor; each is compared field by field.
`timescale 1ns / 1ps

module poisson_pmf_cdf_evaluator_top_tb;

   localparam int PRODUCT_W    = ppce_pkg::TERM_W + ppce_pkg::RATE_W;
   localparam int DIRECTED_LEN = 27;
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 50;
   localparam int MAX_GAP      = 19;
   // Longest latency of one word plus the sender's longest gap and handshake slack.
   localparam int SLOWEST_ITEM = 16 * ppce_pkg::MAX_K + 9 + MAX_GAP + 3;
   localparam int TAIL_CYCLES  = 16 * ppce_pkg::MAX_K + 20;
   localparam int RUN_LIMIT    = 4 * (DIRECTED_LEN + RAND_PHASES * PHASE_ITEMS + 20)
                                 * SLOWEST_ITEM;

   // Register indexes as used by the directed table.
   localparam logic [ppce_pkg::CSR_INDEX_W-1:0] IDX_RATE = ppce_pkg::CSR_RATE;
   localparam logic [ppce_pkg::CSR_INDEX_W-1:0] IDX_EXP  = ppce_pkg::CSR_EXP;

   typedef enum logic {
      ROW_SEND,
      ROW_WRITE
   } row_kind_type;

   // One row of the directed table: a request word or a register write.
   typedef struct packed {
      row_kind_type                        kind;
      logic [ppce_pkg::CSR_INDEX_W-1:0]    index;
      logic [ppce_pkg::CSR_W-1:0]          data;
      logic signed [ppce_pkg::COUNT_W-1:0] count;
      logic                                typed;
      logic [ppce_pkg::OUT_W-1:0]          mass;
      logic [ppce_pkg::OUT_W-1:0]          cum;
   } stim_row_type;

   // Expected response word, tagged with its count for messages.
   typedef struct packed {
      logic signed [ppce_pkg::COUNT_W-1:0] count;
      logic [ppce_pkg::OUT_W-1:0]          mass;
      logic [ppce_pkg::OUT_W-1:0]          cum;
   } probs_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic signed [ppce_pkg::COUNT_W-1:0] req_event_count = '0;
   logic                                rsp_valid;
   logic [ppce_pkg::OUT_W-1:0]          rsp_mass_prob;
   logic [ppce_pkg::OUT_W-1:0]          rsp_cumulative_prob;
   logic                                csr_write_enable = 1'b0;
   logic [ppce_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [ppce_pkg::CSR_W-1:0]          csr_write_data = '0;

   // Shadow copy of the two registers.
   logic [ppce_pkg::RATE_W-1:0] rate_setting = ppce_pkg::RATE_W'(65536);
   logic [ppce_pkg::EXP_W-1:0]  exp_setting  = ppce_pkg::EXP_W'(1580030169);

   probs_type expected_probs[$];
   int        mismatch_count  = 0;
   int        cycle_count     = 0;
   int        words_sent      = 0;
   int        negative_sent   = 0;
   int        max_count_sent  = 0;
   int        results_seen    = 0;
   int        writes_done     = 0;

   stim_row_type directed_rows [DIRECTED_LEN] = '{
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd0,    1'b1, 32'd1580030169, 32'd1580030169},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd1,    1'b1, 32'd1580030169, 32'd3160060338},
      '{ROW_SEND,  IDX_RATE, 32'd0,          -9'sd1,   1'b1, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          -9'sd256, 1'b1, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd255,  1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd2,    1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd127,  1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_RATE, 32'd1048576,    9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_EXP,  32'd483,        9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd0,    1'b1, 32'd483,        32'd483},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd16,   1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd255,  1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_RATE, 32'd0,          9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_EXP,  32'hFFFF_FFFF,  9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd7,    1'b1, 32'd0,          32'hFFFF_FFFF},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd255,  1'b1, 32'd0,          32'hFFFF_FFFF},
      '{ROW_WRITE, IDX_RATE, 32'hFFFF_FFFF,  9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_EXP,  32'd1,          9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd255,  1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd3,    1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_EXP,  32'd0,          9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd100,  1'b1, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_RATE, 32'hFFE3_0000,  9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_WRITE, IDX_EXP,  32'd213833830,  9'sd0,    1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd10,   1'b0, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          -9'sd128, 1'b1, 32'd0,          32'd0},
      '{ROW_SEND,  IDX_RATE, 32'd0,          9'sd64,   1'b0, 32'd0,          32'd0}
   };

   poisson_pmf_cdf_evaluator_top u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_event_count     (req_event_count),
      .rsp_valid           (rsp_valid),
      .rsp_mass_prob       (rsp_mass_prob),
      .rsp_cumulative_prob (rsp_cumulative_prob),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // Free-running clock, 2 ns period.
   initial begin
      forever #1 clock = ~clock;
   end

   // Scales a UQ32.32 value by e^-rate and saturates to UQ0.32.
   function automatic logic [ppce_pkg::OUT_W-1:0] scale_by_exp(
         input logic [ppce_pkg::TERM_W-1:0] x);
      logic [ppce_pkg::TERM_W+ppce_pkg::EXP_W-1:0] wide;
      wide = ({{ppce_pkg::EXP_W{1'b0}}, x} * {{ppce_pkg::TERM_W{1'b0}}, exp_setting})
             >> ppce_pkg::EXP_W;
      if (|wide[ppce_pkg::TERM_W+ppce_pkg::EXP_W-1:ppce_pkg::OUT_W])
         return '1;
      return wide[ppce_pkg::OUT_W-1:0];
   endfunction

   // Builds rate^n/n! term by term, sums the terms, then scales both by e^-rate.
   function automatic probs_type poisson_mass_cum(
         input logic signed [ppce_pkg::COUNT_W-1:0] count);
      logic [ppce_pkg::TERM_W-1:0] term;
      logic [ppce_pkg::TERM_W-1:0] total;
      logic [PRODUCT_W-1:0]        quotient;
      logic [ppce_pkg::TERM_W:0]   acc;
      int                          n;
      int                          last;
      probs_type                   p;
      p.count = count;
      p.mass  = '0;
      p.cum   = '0;
      if (count < 0)
         return p;
      last = count;
      if (last > ppce_pkg::MAX_K)
         last = ppce_pkg::MAX_K;
      term  = ppce_pkg::TERM_W'(1) << ppce_pkg::HALF_W;
      total = term;
      for (n = 1; n <= last; n++) begin
         quotient = ((PRODUCT_W'(term) * PRODUCT_W'(rate_setting)) >> ppce_pkg::RATE_FRAC)
                    / PRODUCT_W'(n);
         if (|quotient[PRODUCT_W-1:ppce_pkg::TERM_W])
            term = '1;
         else
            term = quotient[ppce_pkg::TERM_W-1:0];
         acc   = {1'b0, total} + {1'b0, term};
         total = acc[ppce_pkg::TERM_W] ? '1 : acc[ppce_pkg::TERM_W-1:0];
      end
      p.mass = scale_by_exp(term);
      p.cum  = scale_by_exp(total);
      return p;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic signed [ppce_pkg::COUNT_W-1:0] count,
                                  input logic [ppce_pkg::OUT_W-1:0] got,
                                  input logic [ppce_pkg::OUT_W-1:0] want);
      $display("mismatch at %0t: %s for count %0d: got %h, want %h",
               $realtime, what, count, got, want);
      mismatch_count++;
   endtask

   // Holds off until every expected response word has come back.
   task automatic wait_drained();
      while (expected_probs.size() != 0)
         @(posedge clock);
   endtask

   // Register write; only issued once the block is idle.
   task automatic write_csr(input logic [ppce_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ppce_pkg::CSR_W-1:0] data);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_index        <= ppce_pkg::CSR_INDEX_W'($urandom);
      csr_write_data   <= $urandom;
      if (index == ppce_pkg::CSR_RATE)
         rate_setting = data[ppce_pkg::RATE_W-1:0];
      else if (index == ppce_pkg::CSR_EXP)
         exp_setting = data[ppce_pkg::EXP_W-1:0];
      writes_done++;
   endtask

   // Offers one request word after a gap and records its expectation on acceptance.
   task automatic send_count(input logic signed [ppce_pkg::COUNT_W-1:0] count, input int gap,
                             input logic typed, input logic [ppce_pkg::OUT_W-1:0] mass,
                             input logic [ppce_pkg::OUT_W-1:0] cum);
      probs_type want;
      @(negedge clock);
      repeat (gap) @(negedge clock);
      start           <= 1'b1;
      req_event_count <= count;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (typed)
         want = '{count: count, mass: mass, cum: cum};
      else
         want = poisson_mass_cum(count);
      expected_probs.push_back(want);
      words_sent++;
      if (count < 0)
         negative_sent++;
      if (count == ppce_pkg::MAX_K)
         max_count_sent++;
      @(negedge clock);
      start           <= 1'b0;
      req_event_count <= ppce_pkg::COUNT_W'($urandom);
   endtask

   // Counts are mostly small to keep the run short; a few reach MAX_K.
   function automatic logic signed [ppce_pkg::COUNT_W-1:0] draw_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return ppce_pkg::COUNT_W'(int'($urandom_range(0, 255)) - 256);
      else if (pick < 70)
         return ppce_pkg::COUNT_W'($urandom_range(0, 15));
      else if (pick < 92)
         return ppce_pkg::COUNT_W'($urandom_range(16, 63));
      else if (pick < 98)
         return ppce_pkg::COUNT_W'($urandom_range(64, 254));
      return ppce_pkg::COUNT_W'(ppce_pkg::MAX_K);
   endfunction

   // Response checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin : check_results
      probs_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_probs.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_mass_prob, '0);
         end else begin
            want = expected_probs.pop_front();
            if (rsp_mass_prob !== want.mass)
               report_mismatch("mass_prob", want.count, rsp_mass_prob, want.mass);
            if (rsp_cumulative_prob !== want.cum)
               report_mismatch("cumulative_prob", want.count, rsp_cumulative_prob, want.cum);
         end
      end
   end

   // Watchdog on the total cycle count.
   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d words outstanding",
               cycle_count, expected_probs.size());
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [ppce_pkg::RATE_W-1:0] rate_pick;
      logic [ppce_pkg::EXP_W-1:0]  exp_pick;
      int                          gap_mode;
      int                          phase;
      int                          i;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes, register corner values and sign handling.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE)
            write_csr(directed_rows[r].index, directed_rows[r].data);
         else
            send_count(directed_rows[r].count, $urandom_range(0, MAX_GAP),
                       directed_rows[r].typed, directed_rows[r].mass, directed_rows[r].cum);
      end

      // Random phases, each with its own register setting and gap pattern.
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase % 6)
            0: rate_pick = ppce_pkg::RATE_W'($urandom_range(1, 1048576));
            1: rate_pick = ppce_pkg::RATE_W'(1048576);
            2: rate_pick = ppce_pkg::RATE_W'(1);
            3: rate_pick = ppce_pkg::RATE_W'($urandom);
            4: rate_pick = '0;
            default: rate_pick = ppce_pkg::RATE_W'($urandom_range(1, 16) * 65536);
         endcase
         case ($urandom_range(0, 3))
            0: exp_pick = ppce_pkg::EXP_W'(1);
            1: exp_pick = '1;
            default: exp_pick = $urandom;
         endcase
         write_csr(ppce_pkg::CSR_RATE,
                   {(ppce_pkg::CSR_W - ppce_pkg::RATE_W)'($urandom), rate_pick});
         write_csr(ppce_pkg::CSR_EXP, exp_pick);
         gap_mode = $urandom_range(0, 2);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // Now and then let the pipeline empty completely before going on.
            if ($urandom_range(0, 29) == 0)
               wait_drained();
            send_count(draw_count(), (gap_mode == 0) ? 0 : $urandom_range(0, MAX_GAP),
                       1'b0, '0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d request words (%0d negative, %0d at count %0d), %0d responses",
               words_sent, negative_sent, max_count_sent, ppce_pkg::MAX_K, results_seen);
      $display("over %0d register writes in %0d cycles, %0d mismatches",
               writes_done, cycle_count, mismatch_count);
      if (mismatch_count == 0 && expected_probs.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/ppce_pkg.sv
rtl/ppce_digit_div.sv
rtl/poisson_pmf_cdf_evaluator_top.sv
rtl/ppce_checker.sv
tb/poisson_pmf_cdf_evaluator_top_tb.sv
